// ===== hdl/cds_pkg.sv =====
package cds_pkg;

    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 240;

    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    localparam int SQ_W     = 2 * CH_W;
    localparam int DIST_W   = 18;
    localparam int ROW_W    = 8;
    localparam int COL_W    = 9;
    localparam int ROWCNT_W = 9;
    localparam int COLCNT_W = 8;
    localparam int FRMCNT_W = 17;

    localparam int OUT_FIELDS_W = 1 + ROW_W + COL_W + ROWCNT_W + COLCNT_W + FRMCNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIST_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_RED    = 2'd0,
        CFG_TARGET_GREEN  = 2'd1,
        CFG_TARGET_BLUE   = 2'd2,
        CFG_DIST_THRESH   = 2'd3
    } cfg_index_t;

    localparam logic [CH_W-1:0]   RESET_RED    = 8'd70;
    localparam logic [CH_W-1:0]   RESET_GREEN  = 8'd100;
    localparam logic [CH_W-1:0]   RESET_BLUE   = 8'd180;
    localparam logic [DIST_W-1:0] RESET_THRESH = 18'd6000;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [DIST_W-1:0] threshold;
    } target_t;

endpackage

// ===== hdl/cds_color_match.sv =====
module cds_color_match (
    input  logic                         aclk,
    input  logic                         load,
    input  logic [cds_pkg::PIX_W-1:0]    pixel_word,
    input  cds_pkg::target_t             target,
    output logic                         matched
);

    logic [cds_pkg::CH_W-1:0]   diff_r;
    logic [cds_pkg::CH_W-1:0]   diff_g;
    logic [cds_pkg::CH_W-1:0]   diff_b;
    logic [cds_pkg::SQ_W-1:0]   sq_r_reg;
    logic [cds_pkg::SQ_W-1:0]   sq_g_reg;
    logic [cds_pkg::SQ_W-1:0]   sq_b_reg;
    logic [cds_pkg::DIST_W-1:0] sq_sum;

    function automatic logic [cds_pkg::CH_W-1:0] abs_diff(
        input logic [cds_pkg::CH_W-1:0] a,
        input logic [cds_pkg::CH_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign diff_r = abs_diff(pixel_word[7:0],   target.red);
    assign diff_g = abs_diff(pixel_word[15:8],  target.green);
    assign diff_b = abs_diff(pixel_word[23:16], target.blue);

    always_ff @(posedge aclk) begin
        if (load) begin
            sq_r_reg <= cds_pkg::SQ_W'(diff_r) * cds_pkg::SQ_W'(diff_r);
            sq_g_reg <= cds_pkg::SQ_W'(diff_g) * cds_pkg::SQ_W'(diff_g);
            sq_b_reg <= cds_pkg::SQ_W'(diff_b) * cds_pkg::SQ_W'(diff_b);
        end
    end

    assign sq_sum = cds_pkg::DIST_W'(sq_r_reg) + cds_pkg::DIST_W'(sq_g_reg)
                  + cds_pkg::DIST_W'(sq_b_reg);
    assign matched = (sq_sum < target.threshold);

endmodule

// ===== hdl/color_distance_segmenter.sv =====
// Squares are registered at input accept, then sum, match and counts onto m_tdata.
// Throughput: one pixel per cycle while the output is not stalled; column histogram RAM
// reads (registered) at accept, writes back in stage 1, forwards on a same-column hit.
// Reset: synchronous, active low; clears position, counts and pipeline valids and
// loads the default target colour and threshold. Histogram RAM is not cleared.
module color_distance_segmenter (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [cds_pkg::PIX_W-1:0]            s_tdata,   // pixel_word
    input  logic [0:0]                           s_tuser,   // frame_start
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // matched, pixel_row, pixel_column, row_match_count, column_match_count,
    // frame_match_count, zero pad
    output logic [cds_pkg::OUT_TDATA_W-1:0]      m_tdata,
    output logic                                 m_tlast,   // frame_end
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cds_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int ROW_W    = cds_pkg::ROW_W;
    localparam int COL_W    = cds_pkg::COL_W;
    localparam int COLCNT_W = cds_pkg::COLCNT_W;
    localparam int ROWCNT_W = cds_pkg::ROWCNT_W;
    localparam int FRMCNT_W = cds_pkg::FRMCNT_W;

    cds_pkg::target_t         target_reg;

    logic [ROW_W-1:0]         row_reg;
    logic [ROW_W-1:0]         row_next;
    logic [COL_W-1:0]         col_reg;
    logic [COL_W-1:0]         col_next;
    logic [ROW_W-1:0]         cur_row;
    logic [COL_W-1:0]         cur_col;
    logic                     row_last;
    logic                     frame_last;
    logic                     accept;

    logic                     s1_valid_reg;
    logic [ROW_W-1:0]         s1_row_reg;
    logic [COL_W-1:0]         s1_col_reg;
    logic                     s1_last_reg;
    logic                     s1_fwd_reg;
    logic [COLCNT_W-1:0]      s1_fwd_val_reg;
    logic                     s1_adv;
    logic                     s1_match;

    logic [COLCNT_W-1:0]      col_mem [cds_pkg::FRAME_WIDTH];
    logic [COLCNT_W-1:0]      mem_rd_reg;
    logic [COLCNT_W-1:0]      col_base;
    logic [COLCNT_W-1:0]      col_cnt;

    logic [ROWCNT_W-1:0]      row_cnt_reg;
    logic [ROWCNT_W-1:0]      row_cnt_next;
    logic [FRMCNT_W-1:0]      frm_cnt_reg;
    logic [FRMCNT_W-1:0]      frm_cnt_next;

    logic                     out_valid_reg;
    logic [cds_pkg::OUT_TDATA_W-1:0] out_data_reg;
    logic                     out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg.red       <= cds_pkg::RESET_RED;
            target_reg.green     <= cds_pkg::RESET_GREEN;
            target_reg.blue      <= cds_pkg::RESET_BLUE;
            target_reg.threshold <= cds_pkg::RESET_THRESH;
        end else if (cfg_valid) begin
            case (cds_pkg::cfg_index_t'(cfg_index))
                cds_pkg::CFG_TARGET_RED:   target_reg.red       <= cfg_data[7:0];
                cds_pkg::CFG_TARGET_GREEN: target_reg.green     <= cfg_data[7:0];
                cds_pkg::CFG_TARGET_BLUE:  target_reg.blue      <= cfg_data[7:0];
                cds_pkg::CFG_DIST_THRESH:  target_reg.threshold <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: position and histogram read
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    assign cur_row    = s_tuser[0] ? '0 : row_reg;
    assign cur_col    = s_tuser[0] ? '0 : col_reg;
    assign row_last   = (cur_col == COL_W'(cds_pkg::FRAME_WIDTH - 1));
    assign frame_last = row_last && (cur_row == ROW_W'(cds_pkg::FRAME_HEIGHT - 1));

    always_comb begin
        row_next = cur_row;
        col_next = cur_col + 1'b1;
        if (frame_last) begin
            row_next = '0;
            col_next = '0;
        end else if (row_last) begin
            row_next = cur_row + 1'b1;
            col_next = '0;
        end
    end

    cds_color_match u_match (
        .aclk       (aclk),
        .load       (accept),
        .pixel_word (s_tdata),
        .target     (target_reg),
        .matched    (s1_match)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else begin
            if (accept) begin
                row_reg    <= row_next;
                col_reg    <= col_next;
                s1_fwd_reg <= s1_adv && (s1_col_reg == cur_col);
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_row_reg     <= cur_row;
            s1_col_reg     <= cur_col;
            s1_last_reg    <= frame_last;
            s1_fwd_val_reg <= col_cnt;
            mem_rd_reg     <= col_mem[cur_col];
        end
        if (s1_adv) begin
            col_mem[s1_col_reg] <= col_cnt;
        end
    end

    // stage 1: match, count update, histogram write-back
    assign col_base = s1_fwd_reg ? s1_fwd_val_reg : mem_rd_reg;
    assign col_cnt  = ((s1_row_reg == '0) ? '0 : col_base) + COLCNT_W'(s1_match);

    assign row_cnt_next = ((s1_col_reg == '0) ? '0 : row_cnt_reg)
                        + ROWCNT_W'(s1_match);
    assign frm_cnt_next = ((s1_col_reg == '0 && s1_row_reg == '0) ? '0 : frm_cnt_reg)
                        + FRMCNT_W'(s1_match);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg   <= '0;
            frm_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) begin
                row_cnt_reg   <= row_cnt_next;
                frm_cnt_reg   <= frm_cnt_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_data_reg <= cds_pkg::OUT_TDATA_W'({frm_cnt_next, col_cnt, row_cnt_next,
                                                   s1_col_reg, s1_row_reg, s1_match});
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== sim/tb.sv =====
module tb;
    import cds_pkg::*;

    localparam int LIMIT_CYCLES  = 4_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_GAP      = 24;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_PIXELS  = 242;

    localparam logic [DIST_W-1:0] THRESH_ALL = 18'd195076;

    localparam int ROW_LSB  = 1;
    localparam int COL_LSB  = ROW_LSB + ROW_W;
    localparam int RCNT_LSB = COL_LSB + COL_W;
    localparam int CCNT_LSB = RCNT_LSB + ROWCNT_W;
    localparam int FCNT_LSB = CCNT_LSB + COLCNT_W;

    typedef struct {
        logic                hit;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [ROWCNT_W-1:0] row_hits;
        logic [COLCNT_W-1:0] col_hits;
        logic [FRMCNT_W-1:0] frame_hits;
        logic                last;
    } seg_result_t;

    typedef enum {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t            kind;
        cfg_index_t            reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [PIX_W-1:0]      pixel;
        logic                  start;
        bit                    typed;
        seg_result_t           want;
    } script_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    cfg_index_t             cfg_index = CFG_TARGET_RED;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    logic [CH_W-1:0]   key_red    = RESET_RED;
    logic [CH_W-1:0]   key_green  = RESET_GREEN;
    logic [CH_W-1:0]   key_blue   = RESET_BLUE;
    logic [DIST_W-1:0] key_thresh = RESET_THRESH;

    int unsigned col_hits [FRAME_WIDTH];
    int unsigned at_row     = 0;
    int unsigned at_col     = 0;
    int unsigned row_hits   = 0;
    int unsigned frame_hits = 0;

    seg_result_t awaited_results [$];
    seg_result_t no_result;
    script_row_t script [$];

    int  mismatches   = 0;
    int  results_seen = 0;
    int  cycles       = 0;
    int  gap_cap      = LONG_GAP;
    int  stall_left   = 0;
    bit  feed_calm    = 1'b0;
    bit  drain_calm   = 1'b0;

    color_distance_segmenter i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic int pick_gap(input bit calm, input int cap);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93 || cap <= 3) return $urandom_range(1, 3);
        return $urandom_range(4, cap);
    endfunction

    function automatic int unsigned chan_sq(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    function automatic seg_result_t classify_pixel(input logic [PIX_W-1:0] pix, input logic start);
        seg_result_t res;
        int unsigned dist_sq;
        bit          row_end;
        if (start) begin
            at_row     = 0;
            at_col     = 0;
            row_hits   = 0;
            frame_hits = 0;
        end
        dist_sq = chan_sq(pix[7:0], key_red) + chan_sq(pix[15:8], key_green)
                + chan_sq(pix[23:16], key_blue);
        res.hit = (dist_sq < key_thresh);
        col_hits[at_col] = ((at_row == 0) ? 0 : col_hits[at_col]) + res.hit;
        row_hits   += res.hit;
        frame_hits += res.hit;
        res.row        = ROW_W'(at_row);
        res.col        = COL_W'(at_col);
        res.row_hits   = ROWCNT_W'(row_hits);
        res.col_hits   = COLCNT_W'(col_hits[at_col]);
        res.frame_hits = FRMCNT_W'(frame_hits);
        row_end  = (at_col == FRAME_WIDTH - 1);
        res.last = row_end && (at_row == FRAME_HEIGHT - 1);
        if (res.last) begin
            at_row     = 0;
            at_col     = 0;
            row_hits   = 0;
            frame_hits = 0;
        end else if (row_end) begin
            at_row++;
            at_col   = 0;
            row_hits = 0;
        end else begin
            at_col++;
        end
        return res;
    endfunction

    function automatic logic [CH_W-1:0] near_level(input logic [CH_W-1:0] center);
        int v;
        v = int'(center) + int'($urandom_range(0, 60)) - 30;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[CH_W-1:0];
    endfunction

    function automatic logic [PIX_W-1:0] draw_pixel();
        if ($urandom_range(0, 2) == 0) return PIX_W'($urandom());
        return {near_level(key_blue), near_level(key_green), near_level(key_red)};
    endfunction

    function automatic script_row_t pixel_step(input logic [PIX_W-1:0] pix, input logic start);
        script_row_t s;
        s.kind      = STEP_PIXEL;
        s.reg_index = CFG_TARGET_RED;
        s.reg_value = '0;
        s.pixel     = pix;
        s.start     = start;
        s.typed     = 1'b0;
        return s;
    endfunction

    function automatic script_row_t checked_step(input logic [PIX_W-1:0] pix, input logic start,
                                                 input logic hit, input int row, input int col,
                                                 input int rh, input int ch, input int fh);
        script_row_t s;
        s = pixel_step(pix, start);
        s.typed           = 1'b1;
        s.want.hit        = hit;
        s.want.row        = ROW_W'(row);
        s.want.col        = COL_W'(col);
        s.want.row_hits   = ROWCNT_W'(rh);
        s.want.col_hits   = COLCNT_W'(ch);
        s.want.frame_hits = FRMCNT_W'(fh);
        s.want.last       = 1'b0;
        return s;
    endfunction

    function automatic script_row_t reg_step(input cfg_index_t idx,
                                             input logic [CFG_DATA_W-1:0] val);
        script_row_t s;
        s = pixel_step('0, 1'b0);
        s.kind      = STEP_WRITE;
        s.reg_index = idx;
        s.reg_value = val;
        return s;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s at result %0d: expected %0d, got %0d",
                         what, results_seen, want, got);
        end
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic start, input bit typed,
                              input seg_result_t want);
        int          gap;
        seg_result_t got;
        if ($urandom_range(0, 149) == 0) feed_calm = !feed_calm;
        gap = pick_gap(feed_calm, gap_cap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        got = classify_pixel(pix, start);
        awaited_results.push_back(typed ? want : got);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TARGET_RED:   key_red    = val[CH_W-1:0];
            CFG_TARGET_GREEN: key_green  = val[CH_W-1:0];
            CFG_TARGET_BLUE:  key_blue   = val[CH_W-1:0];
            CFG_DIST_THRESH:  key_thresh = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) drain_calm = !drain_calm;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            stall_left = pick_gap(drain_calm, gap_cap);
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge aclk) begin : watch_results
        seg_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h with nothing awaited", m_tdata);
            end else begin
                want = awaited_results.pop_front();
                check_field("matched", 32'(want.hit), 32'(m_tdata[0]));
                check_field("pixel_row", 32'(want.row), 32'(m_tdata[COL_LSB-1:ROW_LSB]));
                check_field("pixel_column", 32'(want.col),
                            32'(m_tdata[RCNT_LSB-1:COL_LSB]));
                check_field("row_match_count", 32'(want.row_hits),
                            32'(m_tdata[CCNT_LSB-1:RCNT_LSB]));
                check_field("column_match_count", 32'(want.col_hits),
                            32'(m_tdata[FCNT_LSB-1:CCNT_LSB]));
                check_field("frame_match_count", 32'(want.frame_hits),
                            32'(m_tdata[FCNT_LSB+FRMCNT_W-1:FCNT_LSB]));
                check_field("frame_end", 32'(want.last), 32'(m_tlast));
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        no_result = '{default: '0};
        script.push_back(checked_step(24'hB46446, 1'b1, 1'b1, 0, 0, 1, 1, 1));
        script.push_back(checked_step(24'h000000, 1'b0, 1'b0, 0, 1, 1, 0, 1));
        script.push_back(checked_step(24'hFFFFFF, 1'b0, 1'b0, 0, 2, 1, 0, 1));
        script.push_back(checked_step(24'hB46447, 1'b0, 1'b1, 0, 3, 2, 1, 2));
        script.push_back(pixel_step(24'h5AAA55, 1'b0));
        script.push_back(checked_step(24'hB46446, 1'b1, 1'b1, 0, 0, 1, 1, 1));
        script.push_back(reg_step(CFG_DIST_THRESH, '0));
        script.push_back(checked_step(24'hB46446, 1'b0, 1'b0, 0, 1, 1, 0, 1));
        script.push_back(reg_step(CFG_DIST_THRESH, THRESH_ALL));
        script.push_back(reg_step(CFG_TARGET_RED, '0));
        script.push_back(reg_step(CFG_TARGET_GREEN, '0));
        script.push_back(reg_step(CFG_TARGET_BLUE, '0));
        script.push_back(checked_step(24'hFFFFFF, 1'b0, 1'b1, 0, 2, 2, 1, 2));
        script.push_back(reg_step(CFG_DIST_THRESH, THRESH_ALL - 18'd1));
        script.push_back(checked_step(24'hFFFFFF, 1'b0, 1'b0, 0, 3, 2, 0, 2));
        script.push_back(reg_step(CFG_TARGET_RED, 18'd255));
        script.push_back(reg_step(CFG_TARGET_GREEN, 18'd255));
        script.push_back(reg_step(CFG_TARGET_BLUE, 18'd255));
        script.push_back(checked_step(24'h000000, 1'b0, 1'b0, 0, 4, 2, 0, 2));
        script.push_back(checked_step(24'h010101, 1'b0, 1'b1, 0, 5, 3, 1, 3));
        script.push_back(reg_step(CFG_DIST_THRESH, 18'd100));
        script.push_back(checked_step(24'hFFFFF5, 1'b0, 1'b0, 0, 6, 3, 0, 3));
        script.push_back(checked_step(24'hF8F8FE, 1'b0, 1'b1, 0, 7, 4, 1, 4));
        script.push_back(pixel_step(24'h123456, 1'b1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            if (script[i].kind == STEP_WRITE)
                write_reg(script[i].reg_index, script[i].reg_value);
            else
                push_pixel(script[i].pixel, script[i].start, script[i].typed, script[i].want);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(CFG_TARGET_RED, CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(CFG_TARGET_GREEN, CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(CFG_TARGET_BLUE, CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(CFG_DIST_THRESH, (p == 2) ? '0 : (p == 4) ? THRESH_ALL
                                                 : CFG_DATA_W'($urandom_range(0, 3000)));
            repeat (PHASE_PIXELS)
                push_pixel(draw_pixel(), $urandom_range(0, 299) == 0, 1'b0, no_result);
        end

        drain_pipeline();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
